FILE: hw/rtl/connection_table_with_idle_aging_assert.svh
// Assertion macros for the connection table with idle aging.
`ifndef CONNECTION_TABLE_WITH_IDLE_AGING_ASSERT_SVH
`define CONNECTION_TABLE_WITH_IDLE_AGING_ASSERT_SVH
`ifndef SYNTHESIS
`define CTIA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("connection table check failed");
`define CTIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("connection table sequencing check failed");
`else
`define CTIA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CTIA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/ctia_pkg.sv
// Shared types and constants of the connection table with idle aging.
package ctia_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [2:0] {
        FN_ADD    = 3'd0,
        FN_TOUCH  = 3'd1,
        FN_REMOVE = 3'd2,
        FN_LOOKUP = 3'd3,
        FN_TICK   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_TIMEOUT  = 2'd0,
        CFG_INTERVAL = 2'd1,
        CFG_SWEEP_EN = 2'd2
    } t_cfg_idx;

    // Result of examining one entry in one scan cycle.
    typedef struct packed {
        logic        hit;
        logic        free;
        logic        expire;
        logic [31:0] age;
    } t_scan_res;

endpackage

FILE: hw/rtl/ctia_entry_unit.sv
// Shared per-entry unit: key match, free check, saturating age and expiry compare.
module ctia_entry_unit
    import ctia_pkg::*;
(
    input  logic        i_valid,
    input  logic [15:0] i_entry_key,
    input  logic [31:0] i_entry_age,
    input  logic [15:0] i_key,
    input  logic [31:0] i_timeout,
    input  logic        i_sweep,
    output t_scan_res   o_res
);

    logic [31:0] w_age_inc;

    // Saturate at all ones.
    assign w_age_inc = (i_entry_age == '1) ? i_entry_age : i_entry_age + 32'd1;

    always_comb begin
        o_res.hit    = i_valid && (i_entry_key == i_key);
        o_res.free   = !i_valid;
        o_res.age    = w_age_inc;
        o_res.expire = i_valid && i_sweep && (w_age_inc > i_timeout);
    end

endmodule

FILE: hw/rtl/connection_table_with_idle_aging.sv
// Top level: connection table sequencer, entry storage and configuration registers.
//
// Each item (add, touch, remove, lookup or tick) scans the table one entry per
// cycle through a single shared compare/age unit, then applies the change in
// S_APPLY. The result strobe o_done rises as S_APPLY ends and busy drops in
// that same cycle, so a new item is taken only once the last one is done; the
// scan length is set by the one-entry-per-cycle table walk. Unused function
// codes give an all-zero result in the cycle after acceptance. Each result is
// on the o_ ports for exactly one cycle while o_done is high and cannot be held
// off by the receiver. The configuration channel is always ready; write it only
// while busy is low.
`include "connection_table_with_idle_aging_assert.svh"

module connection_table_with_idle_aging
    import ctia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_local_port,
    input  logic [31:0] i_remote_address,
    input  logic [15:0] i_remote_port_in,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [31:0] o_remote_address_out,
    output logic [15:0] o_remote_port_out,
    output logic [4:0]  o_expired_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    t_state r_state;
    t_func  r_op;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_slot;
    logic [IDX_W-1:0] r_fslot;
    logic             r_hit;
    logic             r_free;
    logic             r_sweep;
    logic [4:0]       r_count;

    logic [31:0] r_timeout;
    logic [31:0] r_interval;
    logic        r_sweep_en;
    logic [31:0] r_countdown;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [15:0]              r_key_arr  [TABLE_ENTRIES];
    logic [31:0]              r_addr_arr [TABLE_ENTRIES];
    logic [15:0]              r_port_arr [TABLE_ENTRIES];
    logic [31:0]              r_age_arr  [TABLE_ENTRIES];

    logic [15:0] r_key;
    logic [31:0] r_in_addr;
    logic [15:0] r_in_port;

    logic        r_done;
    t_status     r_status;
    logic        r_found;
    logic [31:0] r_addr_out;
    logic [15:0] r_port_out;
    logic [4:0]  r_exp_out;

    logic        w_accept;
    logic        w_last;
    logic [31:0] n_cd_inc;
    logic [31:0] w_period;
    logic        n_sweep;
    logic [31:0] n_countdown;
    logic [IDX_W-1:0] w_add_slot;
    t_scan_res   w_res;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_last      = (r_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign w_add_slot  = r_hit ? r_slot : r_fslot;

    assign o_done               = r_done;
    assign o_status             = r_status;
    assign o_found              = r_found;
    assign o_remote_address_out = r_addr_out;
    assign o_remote_port_out    = r_port_out;
    assign o_expired_count      = r_exp_out;

    // Decide at tick acceptance whether this tick sweeps.
    always_comb begin
        n_cd_inc = (r_countdown == '1) ? r_countdown : r_countdown + 32'd1;
        w_period = (r_interval == '0) ? 32'd1 : r_interval;
        n_sweep  = r_sweep_en && (n_cd_inc >= w_period);
        if (!r_sweep_en || n_sweep) begin
            n_countdown = '0;
        end else begin
            n_countdown = n_cd_inc;
        end
    end

    ctia_entry_unit u_entry (
        .i_valid     (r_valid[r_idx]),
        .i_entry_key (r_key_arr[r_idx]),
        .i_entry_age (r_age_arr[r_idx]),
        .i_key       (r_key),
        .i_timeout   (r_timeout),
        .i_sweep     (r_sweep),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= FN_ADD;
            r_idx       <= '0;
            r_slot      <= '0;
            r_fslot     <= '0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_sweep     <= 1'b0;
            r_count     <= '0;
            r_timeout   <= 32'd30000;
            r_interval  <= 32'd1000;
            r_sweep_en  <= 1'b0;
            r_countdown <= '0;
            r_valid     <= '0;
            r_done      <= 1'b0;
            r_status    <= ST_OK;
            r_found     <= 1'b0;
            r_addr_out  <= '0;
            r_port_out  <= '0;
            r_exp_out   <= '0;
        end else begin
            r_done <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                    CFG_INTERVAL: r_interval <= i_cfg_data;
                    CFG_SWEEP_EN: r_sweep_en <= i_cfg_data[0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op       <= t_func'(i_func);
                        r_idx      <= '0;
                        r_hit      <= 1'b0;
                        r_free     <= 1'b0;
                        r_count    <= '0;
                        r_sweep    <= 1'b0;
                        r_addr_out <= '0;
                        r_port_out <= '0;
                        unique case (t_func'(i_func)) inside
                            FN_ADD, FN_TOUCH, FN_REMOVE, FN_LOOKUP: begin
                                r_state <= S_SCAN;
                            end
                            FN_TICK: begin
                                r_sweep     <= n_sweep;
                                r_countdown <= n_countdown;
                                r_state     <= S_SCAN;
                            end
                            default: begin
                                // No operation: all-zero result right away.
                                r_done    <= 1'b1;
                                r_status  <= ST_OK;
                                r_found   <= 1'b0;
                                r_exp_out <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_op == FN_TICK) begin
                        if (w_res.expire) begin
                            r_valid[r_idx] <= 1'b0;
                            if (r_count != '1) begin
                                r_count <= r_count + 5'd1;
                            end
                        end
                    end else begin
                        if (w_res.hit && !r_hit) begin
                            r_hit      <= 1'b1;
                            r_slot     <= r_idx;
                            r_addr_out <= r_addr_arr[r_idx];
                            r_port_out <= r_port_arr[r_idx];
                        end
                        if (w_res.free && !r_free) begin
                            r_free  <= 1'b1;
                            r_fslot <= r_idx;
                        end
                    end
                    if (w_last) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_APPLY: begin
                    r_state   <= S_IDLE;
                    r_done    <= 1'b1;
                    r_found   <= (r_op == FN_TICK) ? 1'b0 : r_hit;
                    r_exp_out <= (r_op == FN_TICK) ? r_count : 5'd0;
                    r_status  <= ST_OK;
                    // Address and port go out only on a lookup hit.
                    if (r_op != FN_LOOKUP || !r_hit) begin
                        r_addr_out <= '0;
                        r_port_out <= '0;
                    end
                    unique case (r_op)
                        FN_ADD: begin
                            if (r_hit || r_free) begin
                                r_valid[w_add_slot] <= 1'b1;
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end
                        FN_REMOVE: begin
                            if (r_hit) begin
                                r_valid[r_slot] <= 1'b0;
                            end else begin
                                r_status <= ST_ABSENT;
                            end
                        end
                        FN_TOUCH, FN_LOOKUP: begin
                            if (!r_hit) begin
                                r_status <= ST_ABSENT;
                            end
                        end
                        default: ;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Entry payload and latched item fields.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key     <= i_local_port;
            r_in_addr <= i_remote_address;
            r_in_port <= i_remote_port_in;
        end
        if (r_state == S_SCAN && r_op == FN_TICK && r_valid[r_idx]) begin
            r_age_arr[r_idx] <= w_res.age;
        end else if (r_state == S_APPLY) begin
            if (r_op == FN_ADD && (r_hit || r_free)) begin
                r_key_arr[w_add_slot]  <= r_key;
                r_addr_arr[w_add_slot] <= r_in_addr;
                r_port_arr[w_add_slot] <= r_in_port;
                r_age_arr[w_add_slot]  <= '0;
            end else if (r_op == FN_TOUCH && r_hit) begin
                r_age_arr[r_slot] <= '0;
            end
        end
    end

    `CTIA_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, r_state == S_IDLE)
    `CTIA_ASSERT_NEXT(a_scan_holds, i_clk, i_rst_n, r_state == S_SCAN && !w_last, r_state == S_SCAN)
    `CTIA_ASSERT_SAME(a_full_not_found, i_clk, i_rst_n, o_done && o_status == ST_FULL, !o_found)
    `CTIA_ASSERT_SAME(a_data_needs_hit, i_clk, i_rst_n, o_done && o_remote_port_out != '0, o_found && o_status == ST_OK)
    `CTIA_ASSERT_SAME(a_expire_ok, i_clk, i_rst_n, o_done && o_expired_count != '0, o_status == ST_OK && !o_found)

endmodule

FILE: verif/connection_table_with_idle_aging_tb.sv
// Self-checking testbench for the connection table with idle aging.
`timescale 1ns / 1ps

module connection_table_with_idle_aging_tb;
    import ctia_pkg::*;

    localparam logic [2:0] FN_UNUSED_5 = 3'd5;
    localparam logic [2:0] FN_UNUSED_7 = 3'd7;
    localparam int KEY_POOL = 24;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 260;

    typedef struct {
        logic [2:0]  func;
        logic [15:0] lport;
        logic [31:0] raddr;
        logic [15:0] rport;
    } conn_op_t;

    typedef struct {
        logic [1:0]  status;
        logic        found;
        logic [31:0] addr;
        logic [15:0] port;
        logic [4:0]  expired;
    } conn_result_t;

    typedef struct {
        conn_op_t     op;
        bit           typed;
        conn_result_t res;
    } dir_row_t;

    typedef struct {
        logic [31:0] timeout;
        logic [31:0] interval;
        logic        enable;
    } sweep_cfg_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_func = '0;
    logic [15:0] i_local_port = '0;
    logic [31:0] i_remote_address = '0;
    logic [15:0] i_remote_port_in = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic        o_found;
    logic [31:0] o_remote_address_out;
    logic [15:0] o_remote_port_out;
    logic [4:0]  o_expired_count;

    connection_table_with_idle_aging u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_func              (i_func),
        .i_local_port        (i_local_port),
        .i_remote_address    (i_remote_address),
        .i_remote_port_in    (i_remote_port_in),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_found             (o_found),
        .o_remote_address_out(o_remote_address_out),
        .o_remote_port_out   (o_remote_port_out),
        .o_expired_count     (o_expired_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the table, sweep counter and registers.
    logic        tbl_valid [TABLE_ENTRIES];
    logic [15:0] tbl_key   [TABLE_ENTRIES];
    logic [31:0] tbl_addr  [TABLE_ENTRIES];
    logic [15:0] tbl_rport [TABLE_ENTRIES];
    logic [31:0] tbl_age   [TABLE_ENTRIES];
    logic [31:0] sweep_cnt;
    logic [31:0] reg_timeout;
    logic [31:0] reg_interval;
    logic        reg_sweep_en;

    conn_result_t conn_result_q[$];
    dir_row_t     dir_rows[$];
    logic [15:0]  key_pool[KEY_POOL];

    int n_fail = 0;
    int n_items = 0;
    int n_results = 0;
    int n_swept = 0;
    int n_full = 0;
    int burst_left = 0;

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_fail++;
    endtask

    function automatic void table_reset();
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_addr[i] = '0;
            tbl_rport[i] = '0;
            tbl_age[i] = '0;
        end
        sweep_cnt = '0;
        reg_timeout = 32'd30000;
        reg_interval = 32'd1000;
        reg_sweep_en = 1'b0;
    endfunction

    // Advance the shadow table by one word and return the result it gives.
    function automatic conn_result_t apply_conn_op(conn_op_t op);
        conn_result_t r;
        int i;
        int slot;
        int freei;
        int unsigned removed;
        logic [31:0] period;
        r = '{default: '0};
        slot = -1;
        freei = -1;
        removed = 0;
        if (op.func <= FN_LOOKUP) begin
            for (i = 0; i < TABLE_ENTRIES; i++)
                if (slot < 0 && tbl_valid[i] && tbl_key[i] == op.lport) slot = i;
            r.found = (slot >= 0);
            if (op.func == FN_ADD) begin
                if (slot < 0) begin
                    for (i = 0; i < TABLE_ENTRIES; i++)
                        if (freei < 0 && !tbl_valid[i]) freei = i;
                    if (freei >= 0) begin
                        tbl_valid[freei] = 1'b1;
                        tbl_key[freei] = op.lport;
                        slot = freei;
                    end
                end
                if (slot >= 0) begin
                    tbl_addr[slot] = op.raddr;
                    tbl_rport[slot] = op.rport;
                    tbl_age[slot] = '0;
                end else begin
                    r.status = ST_FULL;
                end
            end else if (slot < 0) begin
                r.status = ST_ABSENT;
            end else if (op.func == FN_TOUCH) begin
                tbl_age[slot] = '0;
            end else if (op.func == FN_REMOVE) begin
                tbl_valid[slot] = 1'b0;
            end else begin
                r.addr = tbl_addr[slot];
                r.port = tbl_rport[slot];
            end
        end else if (op.func == FN_TICK) begin
            for (i = 0; i < TABLE_ENTRIES; i++)
                if (tbl_valid[i] && tbl_age[i] != '1) tbl_age[i] = tbl_age[i] + 1;
            if (!reg_sweep_en) begin
                sweep_cnt = '0;
            end else begin
                // a zero interval sweeps on every tick
                period = (reg_interval == '0) ? 32'd1 : reg_interval;
                if (sweep_cnt != '1) sweep_cnt = sweep_cnt + 1;
                if (sweep_cnt >= period) begin
                    sweep_cnt = '0;
                    for (i = 0; i < TABLE_ENTRIES; i++) begin
                        if (tbl_valid[i] && tbl_age[i] > reg_timeout) begin
                            tbl_valid[i] = 1'b0;
                            removed++;
                        end
                    end
                end
            end
            r.expired = (removed > 31) ? 5'd31 : removed[4:0];
        end
        return r;
    endfunction

    function automatic conn_op_t rand_conn_op();
        conn_op_t op;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) op.func = FN_ADD;
        else if (sel < 45) op.func = FN_TOUCH;
        else if (sel < 57) op.func = FN_REMOVE;
        else if (sel < 72) op.func = FN_LOOKUP;
        else if (sel < 95) op.func = FN_TICK;
        else op.func = 3'($urandom_range(FN_UNUSED_5, FN_UNUSED_7));
        // mostly reuse a small key set so the table fills, hits and overflows
        if ($urandom_range(0, 4) == 0) op.lport = 16'($urandom);
        else op.lport = key_pool[$urandom_range(0, KEY_POOL - 1)];
        op.raddr = $urandom;
        op.rport = 16'($urandom);
        return op;
    endfunction

    task automatic add_row(logic [2:0] f, logic [15:0] p, logic [31:0] a, logic [15:0] rp,
                           bit typed, logic [1:0] st, logic fd, logic [31:0] ao,
                           logic [15:0] po, logic [4:0] ex);
        dir_row_t row;
        row.op = '{func: f, lport: p, raddr: a, rport: rp};
        row.typed = typed;
        row.res = '{status: st, found: fd, addr: ao, port: po, expired: ex};
        dir_rows.push_back(row);
    endtask

    // Present one word and hold it until the block takes it.
    task automatic send_op(conn_op_t op, bit typed, conn_result_t typed_res);
        conn_result_t r;
        start <= 1'b1;
        i_func <= op.func;
        i_local_port <= op.lport;
        i_remote_address <= op.raddr;
        i_remote_port_in <= op.rport;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        r = apply_conn_op(op);
        conn_result_q.push_back(typed ? typed_res : r);
        n_items++;
    endtask

    // Bursts of back-to-back words, then a random gap.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (conn_result_q.size() != 0 || busy);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            CFG_TIMEOUT:  reg_timeout = data;
            CFG_INTERVAL: reg_interval = data;
            CFG_SWEEP_EN: reg_sweep_en = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Check every result word against the oldest expectation.
    always @(posedge i_clk) begin
        conn_result_t e;
        if (i_rst_n && o_done) begin
            n_results++;
            if (conn_result_q.size() == 0) begin
                report_mismatch("result word with nothing awaited");
            end else begin
                e = conn_result_q.pop_front();
                if (o_status !== e.status)
                    report_mismatch($sformatf("status exp %0d got %0d", e.status, o_status));
                if (o_found !== e.found)
                    report_mismatch($sformatf("found exp %0d got %0d", e.found, o_found));
                if (o_remote_address_out !== e.addr)
                    report_mismatch($sformatf("remote_address exp %h got %h",
                                              e.addr, o_remote_address_out));
                if (o_remote_port_out !== e.port)
                    report_mismatch($sformatf("peer port exp %h got %h",
                                              e.port, o_remote_port_out));
                if (o_expired_count !== e.expired)
                    report_mismatch($sformatf("expired_count exp %0d got %0d",
                                              e.expired, o_expired_count));
                n_swept += e.expired;
                if (e.status == ST_FULL) n_full++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Timeout: run did not complete");
        $display("Some tests failed");
        $finish;
    end

    initial begin
        sweep_cfg_t phase_cfg[PHASES];
        conn_result_t none;
        int k;
        int p;
        none = '{default: '0};
        table_reset();
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (k = 2; k < KEY_POOL; k++) key_pool[k] = 16'($urandom);

        // Reset registers: timeout 30000, interval 1000, sweeping off.
        add_row(FN_LOOKUP, 16'h0000, 32'h0, 16'h0, 1, ST_ABSENT, 0, 32'h0, 16'h0, 0);
        add_row(FN_TOUCH, 16'hFFFF, 32'h0, 16'h0, 1, ST_ABSENT, 0, 32'h0, 16'h0, 0);
        add_row(FN_REMOVE, 16'h1234, 32'h0, 16'h0, 1, ST_ABSENT, 0, 32'h0, 16'h0, 0);
        add_row(FN_UNUSED_7, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 1, ST_OK, 0, 32'h0, 16'h0, 0);
        add_row(FN_TICK, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 1, ST_OK, 0, 32'h0, 16'h0, 0);
        add_row(FN_ADD, 16'h0000, 32'hFFFFFFFF, 16'hFFFF, 1, ST_OK, 0, 32'h0, 16'h0, 0);
        add_row(FN_ADD, 16'hFFFF, 32'h0, 16'h0, 1, ST_OK, 0, 32'h0, 16'h0, 0);
        add_row(FN_LOOKUP, 16'h0000, 32'h0, 16'h0, 1, ST_OK, 1, 32'hFFFFFFFF, 16'hFFFF, 0);
        add_row(FN_ADD, 16'h0000, 32'h12345678, 16'hABCD, 1, ST_OK, 1, 32'h0, 16'h0, 0);
        add_row(FN_TOUCH, 16'hFFFF, 32'h0, 16'h0, 1, ST_OK, 1, 32'h0, 16'h0, 0);
        // fill the remaining slots
        for (k = 1; k <= TABLE_ENTRIES - 2; k++)
            add_row(FN_ADD, 16'(k), $urandom, 16'($urandom), 0, ST_OK, 0, 32'h0, 16'h0, 0);
        add_row(FN_ADD, 16'h8000, 32'hA5A5A5A5, 16'h5A5A, 1, ST_FULL, 0, 32'h0, 16'h0, 0);
        add_row(FN_REMOVE, 16'hFFFF, 32'h0, 16'h0, 1, ST_OK, 1, 32'h0, 16'h0, 0);
        add_row(FN_LOOKUP, 16'h0000, 32'h0, 16'h0, 1, ST_OK, 1, 32'h12345678, 16'hABCD, 0);

        phase_cfg[0] = '{timeout: 32'd0, interval: 32'd0, enable: 1'b1};
        phase_cfg[1] = '{timeout: 32'd3, interval: 32'd1, enable: 1'b1};
        phase_cfg[2] = '{timeout: 32'd5, interval: 32'd4, enable: 1'b1};
        phase_cfg[3] = '{timeout: 32'd2, interval: 32'd3, enable: 1'b0};
        phase_cfg[4] = '{timeout: 32'hFFFFFFFF, interval: 32'hFFFFFFFF, enable: 1'b1};
        phase_cfg[5] = '{timeout: 32'd10, interval: 32'd2, enable: 1'b1};
        phase_cfg[6] = '{timeout: $urandom_range(0, 20), interval: $urandom_range(1, 8),
                         enable: 1'($urandom_range(0, 1))};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_op(dir_rows[r].op, dir_rows[r].typed, dir_rows[r].res);
            pace_sender();
        end
        start <= 1'b0;
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            write_reg(CFG_TIMEOUT, phase_cfg[p].timeout);
            write_reg(CFG_INTERVAL, phase_cfg[p].interval);
            write_reg(CFG_SWEEP_EN, {31'd0, phase_cfg[p].enable});
            for (k = 0; k < PHASE_ITEMS; k++) begin
                send_op(rand_conn_op(), 0, none);
                pace_sender();
            end
            start <= 1'b0;
            wait_drained();
        end

        // let any stray word show up
        repeat (40) @(posedge i_clk);
        if (conn_result_q.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", conn_result_q.size()));

        $display("Covered %0d words (%0d directed) over %0d register settings, %0d results.",
                 n_items, dir_rows.size(), PHASES + 1, n_results);
        $display("Sweeps aged out %0d entries; %0d adds were refused on a full table.",
                 n_swept, n_full);
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ctia_pkg.sv
hw/rtl/ctia_entry_unit.sv
hw/rtl/connection_table_with_idle_aging.sv
verif/connection_table_with_idle_aging_tb.sv
